>>> design/ftrc_pkg.sv
// Shared types and constants for the five-tuple rule classifier.
// Depends on nothing; every design file imports it.
package ftrc_pkg;

	localparam int MAX_RULES = 64;
	localparam int IDX_W     = $clog2(MAX_RULES);
	localparam int CNT_W     = $clog2(MAX_RULES + 1);
	localparam int RC_W      = 7;

	localparam logic OP_CLASSIFY = 1'b0;
	localparam logic OP_WRITE    = 1'b1;

	localparam logic [7:0] PROTO_EXACT = 8'hFF;
	localparam logic [7:0] PROTO_ANY   = 8'h00;

	typedef struct packed {
		logic        opcode;
		logic [5:0]  entry_index;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0]  protocol;
		logic [63:0] rule_src_ip_range;
		logic [63:0] rule_dst_ip_range;
		logic [31:0] rule_src_port_range;
		logic [31:0] rule_dst_port_range;
		logic [31:0] rule_proto_and_id;
	} in_t;

	typedef struct packed {
		logic        hit;
		logic [15:0] rule_id;
	} out_t;

	typedef struct packed {
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0]  protocol;
	} pkt_t;

	// Port range: bits 31:0 source range, bits 63:32 destination range.
	typedef struct packed {
		logic [63:0] src_ip_range;
		logic [63:0] dst_ip_range;
		logic [63:0] port_range;
		logic [31:0] proto_and_id;
	} rule_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESULT
	} state_t;

endpackage

>>> design/five_tuple_rule_classifier_top.sv
// Top level of the five-tuple rule classifier: rule memory, scan sequencer
// and output register. Depends on ftrc_pkg and ftrc_match.
//
// Usage:
//   in_valid/in_stall/in_data carry items. A write item (opcode 1) stores
//   one rule at entry_index in the rule memory in the transfer cycle and
//   yields no result; the next item can follow in the next cycle.
//   A classify item (opcode 0) scans rules 0..rule_count-1 (rule_count
//   saturates at MAX_RULES) and yields one result on out_valid/out_stall/
//   out_data: hit and the id of the first matching rule, or hit 0, id 0.
//   The scan reads one rule per cycle from a single-port memory with a
//   registered read, and stops at the first matching rule or after the
//   last rule (at most the saturated rule_count). in_stall is high from
//   the classify transfer until the result is loaded into the output
//   register.
//   cfg_we/cfg_wdata write rule_count; write it only while the block is idle.
//   Reset clears rule_count, the sequencer and out_valid; the rule memory
//   holds no defined contents until written.
//   While the receiver stalls, the result waits in the output register and
//   the block still takes items; a second result waits in the sequencer
//   until the output register frees up.
module five_tuple_rule_classifier_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  ftrc_pkg::in_t                  in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output ftrc_pkg::out_t                 out_data,
	input  logic                           cfg_we,
	input  logic [ftrc_pkg::RC_W-1:0]      cfg_wdata
);
	import ftrc_pkg::*;

	state_t            state_q;
	state_t            state_d;
	logic [RC_W-1:0]   rule_count_q;
	logic [CNT_W-1:0]  limit_q;
	logic [CNT_W-1:0]  limit_d;
	logic [CNT_W-1:0]  idx_q;
	pkt_t              pkt_q;
	rule_t             rule_mem [MAX_RULES];
	rule_t             rd_data_s1;
	logic              rd_vld_s1;
	logic              rd_last_s1;
	logic              res_hit_q;
	logic [15:0]       res_id_q;
	logic              out_valid_q;
	out_t              out_q;

	logic              in_fire;
	logic              cls_fire;
	logic              wr_fire;
	logic              rule_match;
	logic              dec_hit;
	logic              dec_miss;
	logic              scan_re;
	logic              out_free;
	logic              load_out;

	assign in_fire  = in_valid && !in_stall;
	assign cls_fire = in_fire && (in_data.opcode == OP_CLASSIFY);
	assign wr_fire  = in_fire && (in_data.opcode == OP_WRITE)
		&& (32'(in_data.entry_index) < MAX_RULES);
	assign out_free = !out_valid_q || !out_stall;

	assign limit_d = (rule_count_q > RC_W'(MAX_RULES)) ? CNT_W'(MAX_RULES)
		: CNT_W'(rule_count_q);

	ftrc_match u_match (
		.pkt   (pkt_q),
		.rule  (rd_data_s1),
		.match (rule_match)
	);

	assign dec_hit  = rd_vld_s1 && rule_match;
	assign dec_miss = rd_vld_s1 && !rule_match && rd_last_s1;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cls_fire) begin
					state_d = (limit_d == '0) ? ST_RESULT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (dec_hit || dec_miss) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		in_stall = 1'b1;
		scan_re  = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE:   in_stall = 1'b0;
			ST_SCAN:   scan_re  = (idx_q < limit_q) && !dec_hit && !dec_miss;
			ST_RESULT: load_out = out_free;
			default:   in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rule_count_q <= '0;
			idx_q        <= '0;
			limit_q      <= '0;
			rd_vld_s1    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= scan_re;
			if (cfg_we) begin
				rule_count_q <= cfg_wdata;
			end
			if (cls_fire) begin
				idx_q   <= '0;
				limit_q <= limit_d;
			end else if (scan_re) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Rule memory: written by write items, read one rule per scan cycle
	always_ff @(posedge clk) begin
		if (wr_fire) begin
			rule_mem[in_data.entry_index[IDX_W-1:0]] <= '{
				src_ip_range: in_data.rule_src_ip_range,
				dst_ip_range: in_data.rule_dst_ip_range,
				port_range:   {in_data.rule_dst_port_range, in_data.rule_src_port_range},
				proto_and_id: in_data.rule_proto_and_id
			};
		end
		if (scan_re) begin
			rd_data_s1 <= rule_mem[idx_q[IDX_W-1:0]];
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (scan_re) begin
			rd_last_s1 <= (idx_q == limit_q - 1'b1);
		end
		if (cls_fire) begin
			pkt_q.src_ip   <= in_data.src_ip;
			pkt_q.dst_ip   <= in_data.dst_ip;
			pkt_q.src_port <= in_data.src_port;
			pkt_q.dst_port <= in_data.dst_port;
			pkt_q.protocol <= in_data.protocol;
			res_hit_q      <= 1'b0;
			res_id_q       <= '0;
		end else if (state_q == ST_SCAN && dec_hit) begin
			res_hit_q <= 1'b1;
			res_id_q  <= rd_data_s1.proto_and_id[31:16];
		end
		if (load_out) begin
			out_q.hit     <= res_hit_q;
			out_q.rule_id <= res_id_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q <= limit_q))
		else $error("scan index ran past the rule limit");

	a_read_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> ($past(state_q) == ST_SCAN))
		else $error("rule read outside a scan");

	a_miss_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.hit || (out_q.rule_id == '0)))
		else $error("miss result carries a nonzero rule id");

	a_write_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_data.opcode == OP_WRITE) |=> (state_q == ST_IDLE))
		else $error("write item left the idle state");

	a_classify_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cls_fire |=> (state_q == ST_SCAN || state_q == ST_RESULT))
		else $error("classify transfer did not start a scan");

endmodule

>>> design/ftrc_match.sv
// Compares one stored rule against a packet five-tuple.
// Depends on ftrc_pkg for the packet and rule types.
module ftrc_match (
	input  ftrc_pkg::pkt_t  pkt,
	input  ftrc_pkg::rule_t rule,
	output logic            match
);
	import ftrc_pkg::*;

	logic [7:0] proto_lo;
	logic [7:0] proto_hi;
	logic       sip_ok;
	logic       dip_ok;
	logic       sport_ok;
	logic       dport_ok;
	logic       proto_ok;

	assign proto_lo = rule.proto_and_id[7:0];
	assign proto_hi = rule.proto_and_id[15:8];

	assign sip_ok = (pkt.src_ip >= rule.src_ip_range[31:0])
		&& (pkt.src_ip <= rule.src_ip_range[63:32]);
	assign dip_ok = (pkt.dst_ip >= rule.dst_ip_range[31:0])
		&& (pkt.dst_ip <= rule.dst_ip_range[63:32]);
	assign sport_ok = (pkt.src_port >= rule.port_range[15:0])
		&& (pkt.src_port <= rule.port_range[31:16]);
	assign dport_ok = (pkt.dst_port >= rule.port_range[47:32])
		&& (pkt.dst_port <= rule.port_range[63:48]);

	// End code 0xFF is an exact match on start, 0x00 matches any protocol.
	always_comb begin
		if (proto_hi == PROTO_EXACT) begin
			proto_ok = (pkt.protocol == proto_lo);
		end else if (proto_hi == PROTO_ANY) begin
			proto_ok = 1'b1;
		end else begin
			proto_ok = (pkt.protocol >= proto_lo) && (pkt.protocol <= proto_hi);
		end
	end

	assign match = sip_ok && dip_ok && sport_ok && dport_ok && proto_ok;

endmodule
